// ===== hw/rtl/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types for the strong probable-prime tester: sequencer states,
// multiplier phases and the multiplier status bundle.
// ----------------------------------------------------------------------------
package mrp_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_REDUCE,
      ST_SKIP,
      ST_SQUARE,
      ST_MULT,
      ST_CHECK,
      ST_LOOP,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      MM_IDLE,
      MM_DOUBLE,
      MM_ADD
   } mm_phase_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

// ===== hw/rtl/miller_rabin_strong_probable_prime_top.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_strong_probable_prime_top
// One-witness strong probable-prime test of an odd candidate.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one beat per test: candidate n and witness base.
//   rsp_ channel returns one beat per test: probable_prime and bad_input.
//   Even n or n below 3 returns bad_input=1, probable_prime=0 with rsp_valid
//   raised once the result state loads the output register. Otherwise n-1
//   is split into 2^s*d (one shift a cycle), the witness is reduced mod n,
//   witness^d mod n is formed by square-and-multiply, then up to s-1
//   squarings follow. Every modular product runs on one bit-serial
//   multiplier, and that multiplier sets the rate.
//   One test is in flight at a time; req_stall is high while it runs.
//   The result sits in an output register; the next request is accepted
//   while rsp_stall holds it. If a second result finishes while the first
//   is still stalled, the sequencer waits before taking another request.
//   Synchronous reset returns to idle with no result pending.
// ----------------------------------------------------------------------------
module miller_rabin_strong_probable_prime_top #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_candidate,
   input  logic [WIDTH-1:0] req_witness,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_probable_prime,
   output logic             rsp_bad_input
);
   import mrp_pkg::*;

   localparam int SW = $clog2(WIDTH);
   localparam int EW = $clog2(WIDTH + 1);

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] nm1_ff, nm1_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [SW-1:0]    s_ff, s_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [EW-1:0]    ecnt_ff, ecnt_in;
   logic [SW-1:0]    loop_ff, loop_in;
   logic             res_prime_ff, res_prime_in;
   logic             res_bad_ff, res_bad_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pp_ff, rsp_pp_in;
   logic             rsp_bad_ff, rsp_bad_in;

   logic             mm_start;
   logic [WIDTH-1:0] mm_a;
   logic [WIDTH-1:0] mm_b;
   logic [WIDTH-1:0] mm_product;
   mm_status_type    mm_status;

   logic req_fire;
   logic bad_req;
   logic last_ebit;
   logic hit_now;
   logic out_free;

   mrp_modmul #(
      .WIDTH(WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (n_ff),
      .product (mm_product),
      .status  (mm_status)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign bad_req   = (req_candidate < WIDTH'(3)) || !req_candidate[0];
   assign last_ebit = (ecnt_ff == EW'(1));
   assign hit_now   = (acc_ff == WIDTH'(1)) || (acc_ff == nm1_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = bad_req ? ST_RESULT : ST_SPLIT;
         end
         ST_SPLIT: begin
            if (d_ff[0]) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (mm_status.done) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (e_ff[WIDTH-1]) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (mm_status.done) begin
               if (e_ff[WIDTH-1]) state_in = ST_MULT;
               else if (last_ebit) state_in = ST_CHECK;
            end
         end
         ST_MULT: begin
            if (mm_status.done) state_in = last_ebit ? ST_CHECK : ST_SQUARE;
         end
         ST_CHECK: begin
            if (hit_now || s_ff <= SW'(1)) state_in = ST_RESULT;
            else state_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (mm_status.done && (mm_product == nm1_ff || loop_ff == SW'(1))) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and multiplier control
   always_comb begin
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      e_in         = e_ff;
      ecnt_in      = ecnt_ff;
      loop_in      = loop_ff;
      res_prime_in = res_prime_ff;
      res_bad_in   = res_bad_ff;
      mm_start     = 1'b0;
      mm_a         = acc_ff;
      mm_b         = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (bad_req) begin
                  nm1_in       = '0;
                  d_in         = '0;
                  s_in         = '0;
                  acc_in       = '0;
                  res_prime_in = 1'b0;
                  res_bad_in   = 1'b1;
               end else begin
                  n_in       = req_candidate;
                  nm1_in     = req_candidate - 1'b1;
                  d_in       = req_candidate - 1'b1;
                  s_in       = '0;
                  base_in    = req_witness;
                  res_bad_in = 1'b0;
               end
            end
         end
         ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + 1'b1;
            end else begin
               // 1 * base mod n reduces the witness
               mm_start = 1'b1;
               mm_a     = WIDTH'(1);
               mm_b     = base_ff;
            end
         end
         ST_REDUCE: begin
            if (mm_status.done) begin
               base_in = mm_product;
               acc_in  = WIDTH'(1);
               e_in    = d_ff;
               ecnt_in = EW'(WIDTH);
            end
         end
         ST_SKIP: begin
            // leading zero exponent bits leave the power at one
            if (!e_ff[WIDTH-1]) begin
               e_in    = e_ff << 1;
               ecnt_in = ecnt_ff - 1'b1;
            end else begin
               mm_start = 1'b1;
            end
         end
         ST_SQUARE: begin
            if (mm_status.done) begin
               acc_in = mm_product;
               if (e_ff[WIDTH-1]) begin
                  mm_start = 1'b1;
                  mm_a     = mm_product;
                  mm_b     = base_ff;
               end else begin
                  e_in    = e_ff << 1;
                  ecnt_in = ecnt_ff - 1'b1;
                  if (!last_ebit) begin
                     mm_start = 1'b1;
                     mm_a     = mm_product;
                     mm_b     = mm_product;
                  end
               end
            end
         end
         ST_MULT: begin
            if (mm_status.done) begin
               acc_in  = mm_product;
               e_in    = e_ff << 1;
               ecnt_in = ecnt_ff - 1'b1;
               if (!last_ebit) begin
                  mm_start = 1'b1;
                  mm_a     = mm_product;
                  mm_b     = mm_product;
               end
            end
         end
         ST_CHECK: begin
            if (hit_now) begin
               res_prime_in = 1'b1;
            end else if (s_ff <= SW'(1)) begin
               res_prime_in = 1'b0;
            end else begin
               loop_in  = s_ff - 1'b1;
               mm_start = 1'b1;
            end
         end
         ST_LOOP: begin
            if (mm_status.done) begin
               acc_in = mm_product;
               if (mm_product == nm1_ff) begin
                  res_prime_in = 1'b1;
               end else if (loop_ff == SW'(1)) begin
                  res_prime_in = 1'b0;
               end else begin
                  loop_in  = loop_ff - 1'b1;
                  mm_start = 1'b1;
                  mm_a     = mm_product;
                  mm_b     = mm_product;
               end
            end
         end
         default: begin
            mm_start = 1'b0;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pp_in    = rsp_pp_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (state_ff == ST_RESULT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_pp_in    = res_prime_ff;
         rsp_bad_in   = res_bad_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nm1_ff       <= '0;
         d_ff         <= '0;
         s_ff         <= '0;
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nm1_ff       <= nm1_in;
         d_ff         <= d_in;
         s_ff         <= s_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      base_ff      <= base_in;
      e_ff         <= e_in;
      ecnt_ff      <= ecnt_in;
      loop_ff      <= loop_in;
      res_prime_ff <= res_prime_in;
      res_bad_ff   <= res_bad_in;
      rsp_pp_ff    <= rsp_pp_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probable_prime = rsp_pp_ff;
   assign rsp_bad_input      = rsp_bad_ff;

`ifndef SYNTH
   a_mm_start_idle: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !mm_status.busy)
      else $error("multiplier started while busy");

   a_bad_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_bad_input && rsp_probable_prime))
      else $error("bad input reported as prime");

   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished result not loaded into output register");
`endif

endmodule

// ===== hw/rtl/mrp_modmul.sv =====
// ----------------------------------------------------------------------------
// mrp_modmul
// Bit-serial modular multiplier: scans op_b from its top bit, doubling the
// partial result mod m and adding op_a mod m where the bit is set. One
// shared adder, one step per cycle. Requires op_a < modulus.
// ----------------------------------------------------------------------------
module mrp_modmul #(
   parameter int WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [WIDTH-1:0]       op_a,
   input  logic [WIDTH-1:0]       op_b,
   input  logic [WIDTH-1:0]       modulus,
   output logic [WIDTH-1:0]       product,
   output mrp_pkg::mm_status_type status
);
   import mrp_pkg::*;

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   mm_phase_type     phase_ff, phase_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   diff;
   logic [WIDTH-1:0] mod_sum;
   logic             last_bit;

   // both operands are below m, so one conditional subtract reduces
   assign sum     = {1'b0, r_ff} + {1'b0, (phase_ff == MM_ADD) ? a_ff : r_ff};
   assign diff    = sum - {1'b0, m_ff};
   assign mod_sum = (sum >= {1'b0, m_ff}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
   assign last_bit = (cnt_ff == '0);

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         MM_IDLE: begin
            if (start) phase_in = MM_DOUBLE;
         end
         MM_DOUBLE: begin
            if (b_ff[WIDTH-1]) phase_in = MM_ADD;
            else if (last_bit) phase_in = MM_IDLE;
         end
         MM_ADD: begin
            phase_in = last_bit ? MM_IDLE : MM_DOUBLE;
         end
         default: phase_in = MM_IDLE;
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      case (phase_ff)
         MM_IDLE: begin
            if (start) begin
               a_in   = op_a;
               b_in   = op_b;
               m_in   = modulus;
               r_in   = '0;
               cnt_in = CW'(WIDTH - 1);
            end
         end
         MM_DOUBLE: begin
            r_in = mod_sum;
            if (!b_ff[WIDTH-1]) begin
               b_in    = b_ff << 1;
               cnt_in  = cnt_ff - 1'b1;
               done_in = last_bit;
            end
         end
         MM_ADD: begin
            r_in    = mod_sum;
            b_in    = b_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            done_in = last_bit;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign product     = r_ff;
   assign status.busy = (phase_ff != MM_IDLE);
   assign status.done = done_ff;

endmodule
